>>> rtl/core/qslerp_pkg.sv
// Shared types, constants and pipeline rank numbers for the quaternion slerp core.
// Used by every file under rtl/core except qslerp_checker; depends on nothing.
package qslerp_pkg;

    localparam int CompW = 16;     // quaternion component width
    localparam int TW    = 15;     // blend and threshold width
    localparam int CordN = 30;     // CORDIC steps
    localparam int SqN   = 31;     // square root result bits
    localparam int DivN  = 40;     // quotient bits
    localparam int CorW  = 34;     // CORDIC datapath width
    localparam int SqW   = 64;     // square root remainder width
    localparam int DvW   = 72;     // divider remainder width
    localparam int WW    = 41;     // signed weight width, Q30

    localparam logic [TW-1:0] ThrReset = 15'd1638;
    localparam logic [TW-1:0] OneFb    = 15'd16384;
    localparam logic signed [CorW-1:0] CordK = 34'sh026DD3B6A;

    localparam logic [31:0] ATAN_TAB [CordN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // pipeline ranks, numbered from the input capture
    localparam int R_DOT  = 1;
    localparam int R_SQP  = 2;
    localparam int R_SQ0  = 3;
    localparam int R_SQE  = R_SQ0 + SqN - 1;
    localparam int R_VC0  = R_SQE + 1;
    localparam int R_VCE  = R_VC0 + CordN - 1;
    localparam int R_PHI  = R_VCE + 1;
    localparam int R_RT0  = R_PHI + 1;
    localparam int R_RTE  = R_RT0 + CordN - 1;
    localparam int R_DVP  = R_RTE + 1;
    localparam int R_DV0  = R_DVP + 1;
    localparam int R_DVE  = R_DV0 + DivN - 1;
    localparam int R_WSEL = R_DVE + 1;
    localparam int R_MUL  = R_WSEL + 1;
    localparam int R_OUT  = R_MUL + 1;

    typedef struct packed {
        logic [SqW-1:0] rem;
        logic [SqN-1:0] res;
    } sq_t;

    typedef struct packed {
        logic signed [CorW-1:0] x;
        logic signed [CorW-1:0] y;
        logic signed [CorW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic [DvW-1:0]  rem;
        logic [DivN-1:0] q;
    } dv_t;

    typedef struct packed {
        logic [3:0][CompW-1:0] a;
        logic [3:0][CompW:0]   b;
        logic [TW-1:0]         t;
        logic                  same;
        logic                  sph;
        logic [13:0]           d14;
        logic [SqN-1:0]        s30;
        logic [1:0]            wneg;
    } side_t;

endpackage

>>> rtl/core/qslerp_sqrt_cell.sv
// One bit of the pipelined integer square root: trial-subtract and shift.
// Depends on qslerp_pkg.
module qslerp_sqrt_cell #(
    parameter int BitK = 0
) (
    input  logic             aclk,
    input  logic             adv,
    input  qslerp_pkg::sq_t  sq_in,
    output qslerp_pkg::sq_t  sq_out
);

    qslerp_pkg::sq_t q_reg;
    qslerp_pkg::sq_t q_next;
    logic [qslerp_pkg::SqW-1:0] trial;

    always_comb begin
        trial = ({{(qslerp_pkg::SqW - qslerp_pkg::SqN){1'b0}}, sq_in.res} << (BitK + 1))
              + (64'd1 << (2 * BitK));
        q_next = sq_in;
        if (sq_in.rem >= trial) begin
            q_next.rem = sq_in.rem - trial;
            q_next.res = sq_in.res | (31'd1 << BitK);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_reg <= q_next;
        end
    end

    assign sq_out = q_reg;

endmodule

>>> rtl/core/qslerp_vec_cell.sv
// One step of the vectoring CORDIC that turns (cos, sin) into an angle.
// Depends on qslerp_pkg.
module qslerp_vec_cell #(
    parameter int Step = 0
) (
    input  logic              aclk,
    input  logic              adv,
    input  qslerp_pkg::cord_t c_in,
    output qslerp_pkg::cord_t c_out
);

    qslerp_pkg::cord_t c_reg;
    qslerp_pkg::cord_t c_next;
    logic signed [qslerp_pkg::CorW-1:0] dx;
    logic signed [qslerp_pkg::CorW-1:0] dy;
    logic signed [qslerp_pkg::CorW-1:0] ang;

    always_comb begin
        dx  = $signed(c_in.y) >>> Step;
        dy  = $signed(c_in.x) >>> Step;
        ang = $signed({2'b00, qslerp_pkg::ATAN_TAB[Step]});
        if (!c_in.y[qslerp_pkg::CorW-1]) begin
            c_next.x = c_in.x + dx;
            c_next.y = c_in.y - dy;
            c_next.z = c_in.z + ang;
        end else begin
            c_next.x = c_in.x - dx;
            c_next.y = c_in.y + dy;
            c_next.z = c_in.z - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

>>> rtl/core/qslerp_rot_cell.sv
// One step of the rotation CORDIC that produces the sine of an angle.
// Depends on qslerp_pkg.
module qslerp_rot_cell #(
    parameter int Step = 0
) (
    input  logic              aclk,
    input  logic              adv,
    input  qslerp_pkg::cord_t c_in,
    output qslerp_pkg::cord_t c_out
);

    qslerp_pkg::cord_t c_reg;
    qslerp_pkg::cord_t c_next;
    logic signed [qslerp_pkg::CorW-1:0] dx;
    logic signed [qslerp_pkg::CorW-1:0] dy;
    logic signed [qslerp_pkg::CorW-1:0] ang;

    always_comb begin
        dx  = $signed(c_in.y) >>> Step;
        dy  = $signed(c_in.x) >>> Step;
        ang = $signed({2'b00, qslerp_pkg::ATAN_TAB[Step]});
        if (!c_in.z[qslerp_pkg::CorW-1]) begin
            c_next.x = c_in.x - dx;
            c_next.y = c_in.y + dy;
            c_next.z = c_in.z - ang;
        end else begin
            c_next.x = c_in.x + dx;
            c_next.y = c_in.y - dy;
            c_next.z = c_in.z + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

>>> rtl/core/qslerp_div_cell.sv
// One quotient bit of the restoring divider, two lanes sharing one divisor.
// Depends on qslerp_pkg.
module qslerp_div_cell #(
    parameter int BitK = 0
) (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [qslerp_pkg::SqN-1:0]  den,
    input  qslerp_pkg::dv_t [1:0]       dv_in,
    output qslerp_pkg::dv_t [1:0]       dv_out
);

    qslerp_pkg::dv_t [1:0] dv_reg;
    qslerp_pkg::dv_t [1:0] dv_next;
    logic [qslerp_pkg::DvW-1:0] shd;

    always_comb begin
        shd = {{(qslerp_pkg::DvW - qslerp_pkg::SqN){1'b0}}, den} << BitK;
        for (int l = 0; l < 2; l++) begin
            dv_next[l] = dv_in[l];
            if (dv_in[l].rem >= shd) begin
                dv_next[l].rem = dv_in[l].rem - shd;
                dv_next[l].q   = dv_in[l].q | (40'd1 << BitK);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg <= dv_next;
        end
    end

    assign dv_out = dv_reg;

endmodule

>>> rtl/core/quaternion_slerp.sv
// Quaternion slerp core: each transaction on the s_ channel carries two Q2.14 quaternions
// and a blend t; one transaction on the m_ channel returns the blended quaternion, saturated,
// and used_spherical. The core takes one transaction every clock cycle while s_ready is high
// and passes each result through a chain of cells (31 square-root cells, two 30-step CORDIC
// rows, 40 divider cells) plus eight rank registers for the dot product, phase multiply and
// output blend. Every rank advances together when the output register is empty or being
// taken, so s_ready falls only while a result waits on m_ready. lerp_threshold is written
// through cfg_we/cfg_wdata and resets to 0.1.
// Depends on qslerp_pkg and the four qslerp_*_cell modules.
module quaternion_slerp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_a_x,
    input  logic [15:0] s_a_y,
    input  logic [15:0] s_a_z,
    input  logic [15:0] s_a_w,
    input  logic [15:0] s_b_x,
    input  logic [15:0] s_b_y,
    input  logic [15:0] s_b_z,
    input  logic [15:0] s_b_w,
    input  logic [14:0] s_blend,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_x,
    output logic [15:0] m_out_y,
    output logic [15:0] m_out_z,
    output logic [15:0] m_out_w,
    output logic        m_used_spherical
);

    localparam int ROut = qslerp_pkg::R_OUT;
    localparam int RWs  = qslerp_pkg::R_WSEL;

    logic adv;
    logic [qslerp_pkg::TW-1:0] thr_reg;
    logic [ROut:0] vld_reg;

    qslerp_pkg::side_t side_reg  [RWs+1];
    qslerp_pkg::side_t side_next [RWs+1];

    // dot product terms
    logic signed [31:0] prod_reg [4];
    logic signed [18:0] dd [4];
    logic signed [32:0] pr [4];
    logic signed [20:0] dsum;
    logic [20:0]        dabs;
    logic signed [22:0] margin;
    logic               dneg;

    logic [27:0]        dsq;
    logic [28:0]        ddiff;
    qslerp_pkg::sq_t    sqp_reg;
    qslerp_pkg::sq_t    sq_q [qslerp_pkg::SqN];

    qslerp_pkg::cord_t  vc_in;
    qslerp_pkg::cord_t  vc_q [qslerp_pkg::CordN];

    logic signed [49:0] thp;
    logic signed [33:0] phi1;
    qslerp_pkg::cord_t  rt0_in_reg;
    qslerp_pkg::cord_t  rt1_in_reg;
    qslerp_pkg::cord_t  rt0_q [qslerp_pkg::CordN];
    qslerp_pkg::cord_t  rt1_q [qslerp_pkg::CordN];

    logic signed [33:0]    sinv [2];
    logic [33:0]           smag [2];
    qslerp_pkg::dv_t [1:0] dvp_reg;
    qslerp_pkg::dv_t [1:0] dv_q [qslerp_pkg::DivN];

    logic signed [qslerp_pkg::WW-1:0] w0_reg;
    logic signed [qslerp_pkg::WW-1:0] w1_reg;
    logic signed [qslerp_pkg::WW-1:0] w0_next;
    logic signed [qslerp_pkg::WW-1:0] w1_next;
    logic signed [qslerp_pkg::WW-1:0] qs [2];

    logic signed [56:0] pa_reg [4];
    logic signed [57:0] pb_reg [4];
    logic               sph_mul_reg;

    logic signed [58:0] vsum [4];
    logic signed [28:0] vshr [4];
    logic [3:0][15:0]   out_reg;
    logic [3:0][15:0]   out_next;
    logic               sph_out_reg;

    function automatic logic dvp_neg(input logic signed [33:0] v);
        return v[33];
    endfunction

    // global advance: hold every rank while a result waits on m_ready
    assign adv     = !vld_reg[ROut] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= qslerp_pkg::ThrReset;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[ROut-1:0], s_valid};
        end
    end

    // rank 0: capture the transaction, clamp t, compare raw bits, form products
    always_comb begin
        side_next[0].a    = {s_a_w, s_a_z, s_a_y, s_a_x};
        side_next[0].b    = {s_b_w[15], s_b_w, s_b_z[15], s_b_z,
                             s_b_y[15], s_b_y, s_b_x[15], s_b_x};
        side_next[0].t    = (s_blend > qslerp_pkg::OneFb) ? qslerp_pkg::OneFb : s_blend;
        side_next[0].same = (s_a_x == s_b_x) && (s_a_y == s_b_y)
                         && (s_a_z == s_b_z) && (s_a_w == s_b_w);
        side_next[0].sph  = 1'b0;
        side_next[0].d14  = '0;
        side_next[0].s30  = '0;
        side_next[0].wneg = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next[0];
            prod_reg[0] <= $signed(s_a_x) * $signed(s_b_x);
            prod_reg[1] <= $signed(s_a_y) * $signed(s_b_y);
            prod_reg[2] <= $signed(s_a_z) * $signed(s_b_z);
            prod_reg[3] <= $signed(s_a_w) * $signed(s_b_w);
        end
    end

    // rank 1: round each product to Q14, sum, fold a negative dot onto b
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pr[i] = 33'(prod_reg[i]) + 33'sd8192;
            dd[i] = pr[i][32:14];
        end
        dsum   = 21'(dd[0]) + 21'(dd[1]) + 21'(dd[2]) + 21'(dd[3]);
        dneg   = dsum[20];
        dabs   = dneg ? 21'(-dsum) : 21'(dsum);
        margin = 23'sd16384 - $signed({2'b00, dabs});
    end

    // side line: carry the item's fields alongside the cells, merging results as they land
    for (genvar i = 1; i <= RWs; i++) begin : g_side
        always_comb begin
            side_next[i] = side_reg[i-1];
            if (i == qslerp_pkg::R_DOT) begin
                for (int k = 0; k < 4; k++) begin
                    side_next[i].b[k] = dneg ? 17'(-$signed(side_reg[i-1].b[k]))
                                             : side_reg[i-1].b[k];
                end
                side_next[i].sph = !side_reg[i-1].same
                                && (margin > $signed({8'b0, thr_reg}));
                side_next[i].d14 = dabs[13:0];
            end
            if (i == qslerp_pkg::R_VC0) begin
                side_next[i].s30 = sq_q[qslerp_pkg::SqN-1].res;
            end
            if (i == qslerp_pkg::R_DVP) begin
                side_next[i].wneg = {dvp_neg(rt1_q[qslerp_pkg::CordN-1].y),
                                     dvp_neg(rt0_q[qslerp_pkg::CordN-1].y)};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // rank 2: remainder for sin(theta) = sqrt(2^60 - d30^2)
    always_comb begin
        dsq   = side_reg[qslerp_pkg::R_DOT].d14 * side_reg[qslerp_pkg::R_DOT].d14;
        ddiff = 29'h1000_0000 - {1'b0, dsq};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqp_reg.rem <= {3'b000, ddiff, 32'h0};
            sqp_reg.res <= '0;
        end
    end

    for (genvar j = 0; j < qslerp_pkg::SqN; j++) begin : g_sq
        if (j == 0) begin : g_first
            qslerp_sqrt_cell #(.BitK(qslerp_pkg::SqN - 1)) u_cell (
                .aclk(aclk), .adv(adv), .sq_in(sqp_reg), .sq_out(sq_q[j]));
        end else begin : g_next
            qslerp_sqrt_cell #(.BitK(qslerp_pkg::SqN - 1 - j)) u_cell (
                .aclk(aclk), .adv(adv), .sq_in(sq_q[j-1]), .sq_out(sq_q[j]));
        end
    end

    // theta = angle of (d30, s30)
    always_comb begin
        vc_in.x = $signed({4'b0000, side_reg[qslerp_pkg::R_SQE].d14, 16'h0});
        vc_in.y = $signed({3'b000, sq_q[qslerp_pkg::SqN-1].res});
        vc_in.z = '0;
    end

    for (genvar j = 0; j < qslerp_pkg::CordN; j++) begin : g_vc
        if (j == 0) begin : g_first
            qslerp_vec_cell #(.Step(j)) u_cell (
                .aclk(aclk), .adv(adv), .c_in(vc_in), .c_out(vc_q[j]));
        end else begin : g_next
            qslerp_vec_cell #(.Step(j)) u_cell (
                .aclk(aclk), .adv(adv), .c_in(vc_q[j-1]), .c_out(vc_q[j]));
        end
    end

    // phase split: phi1 = floor(theta * t), phi0 = theta - phi1
    always_comb begin
        thp  = vc_q[qslerp_pkg::CordN-1].z
             * $signed({1'b0, side_reg[qslerp_pkg::R_VCE].t});
        phi1 = thp[47:14];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rt0_in_reg.x <= qslerp_pkg::CordK;
            rt0_in_reg.y <= '0;
            rt0_in_reg.z <= vc_q[qslerp_pkg::CordN-1].z - phi1;
            rt1_in_reg.x <= qslerp_pkg::CordK;
            rt1_in_reg.y <= '0;
            rt1_in_reg.z <= phi1;
        end
    end

    for (genvar j = 0; j < qslerp_pkg::CordN; j++) begin : g_rt
        if (j == 0) begin : g_first
            qslerp_rot_cell #(.Step(j)) u_cell0 (
                .aclk(aclk), .adv(adv), .c_in(rt0_in_reg), .c_out(rt0_q[j]));
            qslerp_rot_cell #(.Step(j)) u_cell1 (
                .aclk(aclk), .adv(adv), .c_in(rt1_in_reg), .c_out(rt1_q[j]));
        end else begin : g_next
            qslerp_rot_cell #(.Step(j)) u_cell0 (
                .aclk(aclk), .adv(adv), .c_in(rt0_q[j-1]), .c_out(rt0_q[j]));
            qslerp_rot_cell #(.Step(j)) u_cell1 (
                .aclk(aclk), .adv(adv), .c_in(rt1_q[j-1]), .c_out(rt1_q[j]));
        end
    end

    // divider prep: magnitude of each sine, shifted to Q60; signs ride the side line
    always_comb begin
        sinv[0] = rt0_q[qslerp_pkg::CordN-1].y;
        sinv[1] = rt1_q[qslerp_pkg::CordN-1].y;
        for (int l = 0; l < 2; l++) begin
            smag[l] = sinv[l][33] ? 34'(-sinv[l]) : 34'(sinv[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                dvp_reg[l].rem <= {8'h00, smag[l], 30'h0};
                dvp_reg[l].q   <= '0;
            end
        end
    end

    for (genvar j = 0; j < qslerp_pkg::DivN; j++) begin : g_dv
        if (j == 0) begin : g_first
            qslerp_div_cell #(.BitK(qslerp_pkg::DivN - 1)) u_cell (
                .aclk(aclk), .adv(adv), .den(side_reg[qslerp_pkg::R_DVP].s30),
                .dv_in(dvp_reg), .dv_out(dv_q[j]));
        end else begin : g_next
            qslerp_div_cell #(.BitK(qslerp_pkg::DivN - 1 - j)) u_cell (
                .aclk(aclk), .adv(adv), .den(side_reg[qslerp_pkg::R_DV0 + j - 1].s30),
                .dv_in(dv_q[j-1]), .dv_out(dv_q[j]));
        end
    end

    // weight select: equal inputs pass a through, else sine or linear weights
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            qs[l] = side_reg[qslerp_pkg::R_DVE].wneg[l]
                  ? -$signed({1'b0, dv_q[qslerp_pkg::DivN-1][l].q})
                  :  $signed({1'b0, dv_q[qslerp_pkg::DivN-1][l].q});
        end
        if (side_reg[qslerp_pkg::R_DVE].same) begin
            w0_next = 41'sh0_4000_0000;
            w1_next = '0;
        end else if (side_reg[qslerp_pkg::R_DVE].sph) begin
            w0_next = qs[0];
            w1_next = qs[1];
        end else begin
            w0_next = $signed({10'h0, 15'(qslerp_pkg::OneFb - side_reg[qslerp_pkg::R_DVE].t),
                               16'h0});
            w1_next = $signed({10'h0, side_reg[qslerp_pkg::R_DVE].t, 16'h0});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                pa_reg[i] <= w0_reg * $signed(side_reg[RWs].a[i]);
                pb_reg[i] <= w1_reg * $signed(side_reg[RWs].b[i]);
            end
            sph_mul_reg <= side_reg[RWs].sph;
        end
    end

    // output: round to Q14, saturate, hold in the output register
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            vsum[i] = 59'(pa_reg[i]) + 59'(pb_reg[i]) + 59'sd536870912;
            vshr[i] = 29'(vsum[i] >>> 30);
            if (vshr[i] > 29'sd32767) begin
                out_next[i] = 16'h7FFF;
            end else if (vshr[i] < -29'sd32768) begin
                out_next[i] = 16'h8000;
            end else begin
                out_next[i] = vshr[i][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg     <= out_next;
            sph_out_reg <= sph_mul_reg;
        end
    end

    assign m_valid          = vld_reg[ROut];
    assign m_out_x          = out_reg[0];
    assign m_out_y          = out_reg[1];
    assign m_out_z          = out_reg[2];
    assign m_out_w          = out_reg[3];
    assign m_used_spherical = sph_out_reg;

endmodule

>>> rtl/core/qslerp_checker.sv
// Port-level checks for the quaternion slerp core, attached by bind.
// Depends on quaternion_slerp's port list only.
module qslerp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_x,
    input logic        m_used_spherical
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    // the input side only backs off while a result waits
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low with a free output register");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("s_ready high while output stalled");

    // a stalled result keeps its x component and used_spherical flag
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_x) && $stable(m_used_spherical))
        else $error("payload changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

endmodule

bind quaternion_slerp qslerp_checker u_qslerp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_out_x(m_out_x),
    .m_used_spherical(m_used_spherical)
);
